[src/pr_pkg.sv]
// pr_pkg: shared codes, state encoding and constants of the pagerank engine
// no dependencies; used by pr_link_store and the engine top
package pr_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_RUN   = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_CONVERGED = 2'd0,
        KIND_LIMIT     = 2'd1,
        KIND_RANK      = 2'd2,
        KIND_BAD       = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_NUM_PAGES = 2'd0,
        CFG_DAMPING   = 2'd1,
        CFG_EPSILON   = 2'd2,
        CFG_MAX_ITER  = 2'd3
    } cfg_addr_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LINK_WR,
        ST_READ_OUT,
        ST_RUN_DIV,
        ST_RUN_INIT,
        ST_SH_RD,
        ST_SH_DIV,
        ST_SH_WAIT,
        ST_TELE_MUL,
        ST_TELE_DIV,
        ST_TELE_WAIT,
        ST_ACC,
        ST_ACC_LAST,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_ITER_END
    } eng_state_t;

    // control strobes toward the link store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } lnk_ctl_t;

    localparam logic [8:0]  NUM_PAGES_RST = 9'd1;
    localparam logic [15:0] DAMPING_RST   = 16'd55706;
    localparam logic [31:0] EPSILON_RST   = 32'd5368709;
    localparam logic [15:0] MAX_ITER_RST  = 16'd1000;
    localparam logic [16:0] DAMP_ONE      = 17'h10000;

endpackage

[src/pr_div.sv]
// pr_div: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters; divisor must be nonzero
module pr_div #(
    parameter int DW = 40,
    parameter int VW = 9
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   rem_sh;
    logic          ge;
    logic [VW:0]   rem_new;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DW-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_new = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= rem_new[VW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/pr_link_store.sv]
// pr_link_store: adjacency row memory and out-degree memory with row valid bits
// depends on pr_pkg for the control struct
module pr_link_store #(
    parameter int MAX_PAGES = 256,
    parameter int AW        = 8,
    parameter int NW        = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pr_pkg::lnk_ctl_t     ctl,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [MAX_PAGES-1:0] wr_row,
    input  logic [NW-1:0]        wr_deg,
    output logic [MAX_PAGES-1:0] rd_row,
    output logic [NW-1:0]        rd_deg
);
    import pr_pkg::*;

    logic [MAX_PAGES-1:0] row_mem [MAX_PAGES];
    logic [NW-1:0]        deg_mem [MAX_PAGES];
    logic [MAX_PAGES-1:0] valid_reg;
    logic [MAX_PAGES-1:0] row_q_reg;
    logic [NW-1:0]        deg_q_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            row_mem[wr_addr] <= wr_row;
            deg_mem[wr_addr] <= wr_deg;
        end
        if (ctl.rd_en) begin
            row_q_reg <= row_mem[rd_addr];
            deg_q_reg <= deg_mem[rd_addr];
        end
    end

    // a cleared graph is all rows invalid; invalid rows read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (ctl.clear) begin
                valid_reg <= '0;
            end else if (ctl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_vld_reg ? row_q_reg : '0;
    assign rd_deg = rd_vld_reg ? deg_q_reg : '0;

endmodule

[src/pagerank_power_iteration_engine.sv]
// pagerank_power_iteration_engine: command decoder, run sequencer, rank and share memories
// depends on pr_pkg, pr_div and pr_link_store
//
// Usage: commands arrive on the s_ channel (valid/ready), results leave on the
// m_ channel. The cfg_ port writes num_pages, damping, epsilon, max_iterations,
// which the user must do only while the block is idle; the block does not enforce it.
//   clear graph: no result. add link: the row is read, then written; no result.
//   read rank: the rank memory is read, then the result register is loaded.
//   run: one result after the whole power iteration. Each iteration runs the
//   per-page share divisions in the shared serial divider (SW = 32 +
//   log2(MAX_PAGES)), the teleport term, the adjacency walk with one link row
//   read per cycle within each page's walk, and the stop check; start first
//   divides for the start rank and writes it to every page.
// Commands are taken one at a time; a new command is taken while the result
// register is empty or being emptied in the same cycle. When the receiver
// stalls, the result holds and intake stops only after that result's command.
// Reset (synchronous, aresetn low) clears the graph, the ranks' valid state
// and the iteration count and restores the register defaults.
module pagerank_power_iteration_engine #(
    parameter int MAX_PAGES      = 256,
    parameter int RANK_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_src_page,
    input  logic [7:0]  s_dst_page,
    input  logic [7:0]  s_query_page,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_page_index,
    output logic [31:0] m_rank,
    output logic [15:0] m_iterations
);
    import pr_pkg::*;

    localparam int AW = $clog2(MAX_PAGES);
    localparam int NW = $clog2(MAX_PAGES + 1);
    localparam int SW = 32 + AW;
    localparam logic [SW-1:0] START_NUM = SW'(64'd1 << RANK_FRAC_BITS);

    // configuration
    logic [8:0]  num_pages_reg;
    logic [15:0] damping_reg;
    logic [31:0] epsilon_reg;
    logic [15:0] max_iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_pages_reg <= NUM_PAGES_RST;
            damping_reg   <= DAMPING_RST;
            epsilon_reg   <= EPSILON_RST;
            max_iter_reg  <= MAX_ITER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_NUM_PAGES: num_pages_reg <= cfg_wdata[8:0];
                CFG_DAMPING:   damping_reg   <= cfg_wdata[15:0];
                CFG_EPSILON:   epsilon_reg   <= cfg_wdata;
                CFG_MAX_ITER:  max_iter_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [NW-1:0] n_pages;
    always_comb begin
        if (num_pages_reg == 9'd0) begin
            n_pages = NW'(1);
        end else if (32'(num_pages_reg) > MAX_PAGES) begin
            n_pages = NW'(MAX_PAGES);
        end else begin
            n_pages = NW'(num_pages_reg);
        end
    end

    // state and datapath registers
    eng_state_t     state_reg, state_next;
    logic [NW-1:0]  j_reg;
    logic [NW-1:0]  i_reg;
    logic [SW-1:0]  total_reg;
    logic [SW-1:0]  dangling_reg;
    logic [SW-1:0]  acc_reg;
    logic [SW-1:0]  tele_reg;
    logic [SW+16:0] tprod_reg;
    logic [SW+15:0] dacc_reg;
    logic [31:0]    start_reg;
    logic [31:0]    rold_reg;
    logic [31:0]    diff_reg;
    logic [63:0]    sq_reg;
    logic [63:0]    change_reg;
    logic [63:0]    epsq_reg;
    logic [15:0]    count_reg;
    logic [15:0]    iter_cnt_reg;
    logic           ranks_valid_reg;
    logic           deg_zero_reg;
    logic           pv_reg;
    logic [AW-1:0]  lsrc_reg;
    logic [AW-1:0]  ldst_reg;
    logic [7:0]     query_reg;

    logic           m_valid_reg;
    kind_t          m_kind_reg;
    logic [7:0]     m_page_reg;
    logic [31:0]    m_rank_reg;
    logic [15:0]    m_iter_reg;

    // rank and share memories
    logic [31:0]          rank_mem  [MAX_PAGES];
    logic [31:0]          share_mem [MAX_PAGES];
    logic [MAX_PAGES-1:0] rank_vld_reg;
    logic [31:0]          rank_q_reg;
    logic                 rank_qv_reg;
    logic [31:0]          share_q_reg;
    logic                 rank_rd_en, rank_we, share_rd_en, share_we;
    logic [AW-1:0]        rank_rd_addr, rank_wr_addr, share_rd_addr, share_wr_addr;
    logic [31:0]          rank_wdata, share_wdata, rank_rd;

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[rank_wr_addr] <= rank_wdata;
        end
        if (rank_rd_en) begin
            rank_q_reg <= rank_mem[rank_rd_addr];
        end
        if (share_we) begin
            share_mem[share_wr_addr] <= share_wdata;
        end
        if (share_rd_en) begin
            share_q_reg <= share_mem[share_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_vld_reg <= '0;
            rank_qv_reg  <= 1'b0;
        end else begin
            if (rank_we) begin
                rank_vld_reg[rank_wr_addr] <= 1'b1;
            end
            if (rank_rd_en) begin
                rank_qv_reg <= rank_vld_reg[rank_rd_addr];
            end
        end
    end

    assign rank_rd = rank_qv_reg ? rank_q_reg : 32'd0;

    // link store
    lnk_ctl_t             lnk_ctl;
    logic [AW-1:0]        lnk_rd_addr;
    logic [MAX_PAGES-1:0] lnk_wr_row, lnk_rd_row;
    logic [NW-1:0]        lnk_wr_deg, lnk_rd_deg;

    pr_link_store #(
        .MAX_PAGES(MAX_PAGES),
        .AW       (AW),
        .NW       (NW)
    ) u_links (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (lnk_ctl),
        .rd_addr(lnk_rd_addr),
        .wr_addr(lsrc_reg),
        .wr_row (lnk_wr_row),
        .wr_deg (lnk_wr_deg),
        .rd_row (lnk_rd_row),
        .rd_deg (lnk_rd_deg)
    );

    // shared divider
    logic          div_start, div_done;
    logic [SW-1:0] div_num, div_quo;
    logic [NW-1:0] div_den;

    pr_div #(
        .DW(SW),
        .VW(NW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_num),
        .divisor (div_den),
        .done    (div_done),
        .quotient(div_quo)
    );

    // helpers
    logic          s_xfer;
    logic [AW+7:0] src_ext, dst_ext, q_ext;
    logic          link_in_range;
    logic [AW-1:0] j_idx, i_idx;
    logic          j_last, i_last;
    logic [SW:0]   vsum;
    logic [31:0]   v32;
    logic [64:0]   csum;
    logic [15:0]   count_new;
    logic          conv;
    logic          run_stop;
    logic          read_bad;

    assign s_xfer        = s_valid && s_ready;
    assign src_ext       = {{AW{1'b0}}, s_src_page};
    assign dst_ext       = {{AW{1'b0}}, s_dst_page};
    assign q_ext         = {{AW{1'b0}}, s_query_page};
    assign link_in_range = (32'(s_src_page) < MAX_PAGES) && (32'(s_dst_page) < MAX_PAGES);
    assign j_idx         = j_reg[AW-1:0];
    assign i_idx         = i_reg[AW-1:0];
    assign j_last        = j_reg == (n_pages - 1'b1);
    assign i_last        = i_reg == (n_pages - 1'b1);
    assign vsum          = {1'b0, dacc_reg[SW+15:16]} + {1'b0, tele_reg};
    assign v32           = (vsum[SW] || (|vsum[SW-1:32])) ? 32'hFFFF_FFFF : vsum[31:0];
    assign csum          = {1'b0, change_reg} + {1'b0, sq_reg};
    assign count_new     = count_reg + 16'd1;
    assign conv          = change_reg < epsq_reg;
    assign run_stop      = conv || (count_new >= max_iter_reg);
    assign read_bad      = !ranks_valid_reg || (32'(query_reg) >= 32'(n_pages));

    // next state and memory strobes
    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        lnk_ctl       = '0;
        lnk_rd_addr   = j_idx;
        lnk_wr_row    = lnk_rd_row | ({{(MAX_PAGES-1){1'b0}}, 1'b1} << ldst_reg);
        lnk_wr_deg    = lnk_rd_deg + 1'b1;
        rank_rd_en    = 1'b0;
        rank_rd_addr  = j_idx;
        rank_we       = 1'b0;
        rank_wr_addr  = j_idx;
        rank_wdata    = start_reg;
        share_rd_en   = 1'b0;
        share_rd_addr = j_idx;
        share_we      = 1'b0;
        share_wr_addr = j_idx;
        share_wdata   = div_quo[31:0];
        div_start     = 1'b0;
        div_num       = START_NUM;
        div_den       = n_pages;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (s_xfer) begin
                    unique case (func_t'(s_func))
                        FUNC_CLEAR: lnk_ctl.clear = 1'b1;
                        FUNC_ADD: begin
                            if (link_in_range) begin
                                lnk_ctl.rd_en = 1'b1;
                                lnk_rd_addr   = src_ext[AW-1:0];
                                state_next    = ST_LINK_WR;
                            end
                        end
                        FUNC_RUN: begin
                            div_start  = 1'b1;
                            state_next = ST_RUN_DIV;
                        end
                        FUNC_READ: begin
                            rank_rd_en   = 1'b1;
                            rank_rd_addr = q_ext[AW-1:0];
                            state_next   = ST_READ_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LINK_WR: begin
                // duplicate links leave row and degree alone
                lnk_ctl.wr_en = !lnk_rd_row[ldst_reg];
                state_next    = ST_IDLE;
            end
            ST_READ_OUT: state_next = ST_IDLE;
            ST_RUN_DIV: begin
                if (div_done) begin
                    state_next = ST_RUN_INIT;
                end
            end
            ST_RUN_INIT: begin
                rank_we = 1'b1;
                if (j_last) begin
                    state_next = ST_SH_RD;
                end
            end
            ST_SH_RD: begin
                lnk_ctl.rd_en = 1'b1;
                rank_rd_en    = 1'b1;
                state_next    = ST_SH_DIV;
            end
            ST_SH_DIV: begin
                div_start  = 1'b1;
                div_num    = SW'(rank_rd);
                div_den    = (lnk_rd_deg == '0) ? n_pages : lnk_rd_deg;
                state_next = ST_SH_WAIT;
            end
            ST_SH_WAIT: begin
                if (div_done) begin
                    share_we   = 1'b1;
                    state_next = j_last ? ST_TELE_MUL : ST_SH_RD;
                end
            end
            ST_TELE_MUL: state_next = ST_TELE_DIV;
            ST_TELE_DIV: begin
                div_start  = 1'b1;
                div_num    = tprod_reg[SW+15:16];
                state_next = ST_TELE_WAIT;
            end
            ST_TELE_WAIT: begin
                if (div_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                // one link row and one share read per cycle, summed in the following cycle
                lnk_ctl.rd_en = 1'b1;
                share_rd_en   = 1'b1;
                if (j_last) begin
                    state_next = ST_ACC_LAST;
                end
            end
            ST_ACC_LAST: begin
                rank_rd_en   = 1'b1;
                rank_rd_addr = i_idx;
                state_next   = ST_MUL1;
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: begin
                rank_we      = 1'b1;
                rank_wr_addr = i_idx;
                rank_wdata   = v32;
                state_next   = ST_MUL3;
            end
            ST_MUL3: state_next = ST_MUL4;
            ST_MUL4: state_next = i_last ? ST_ITER_END : ST_ACC;
            ST_ITER_END: state_next = run_stop ? ST_IDLE : ST_SH_RD;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            ranks_valid_reg <= 1'b0;
            iter_cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_READ_OUT) begin
                m_valid_reg <= 1'b1;
            end
            if (state_reg == ST_ITER_END && run_stop) begin
                m_valid_reg     <= 1'b1;
                ranks_valid_reg <= 1'b1;
                iter_cnt_reg    <= count_new;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                lsrc_reg   <= src_ext[AW-1:0];
                ldst_reg   <= dst_ext[AW-1:0];
                query_reg  <= s_query_page;
                j_reg      <= '0;
                count_reg  <= '0;
                total_reg  <= '0;
                dangling_reg <= '0;
                change_reg <= '0;
                epsq_reg   <= epsilon_reg * epsilon_reg;
            end
            ST_READ_OUT: begin
                m_page_reg <= query_reg;
                if (read_bad) begin
                    m_kind_reg <= KIND_BAD;
                    m_rank_reg <= '0;
                    m_iter_reg <= '0;
                end else begin
                    m_kind_reg <= KIND_RANK;
                    m_rank_reg <= rank_rd;
                    m_iter_reg <= iter_cnt_reg;
                end
            end
            ST_RUN_DIV: start_reg <= div_quo[31:0];
            ST_RUN_INIT: j_reg <= j_last ? '0 : j_reg + 1'b1;
            ST_SH_DIV: begin
                total_reg    <= total_reg + SW'(rank_rd);
                deg_zero_reg <= lnk_rd_deg == '0;
            end
            ST_SH_WAIT: begin
                if (div_done) begin
                    if (deg_zero_reg) begin
                        dangling_reg <= dangling_reg + SW'(div_quo[31:0]);
                    end
                    j_reg <= j_last ? '0 : j_reg + 1'b1;
                end
            end
            ST_TELE_MUL: tprod_reg <= (DAMP_ONE - {1'b0, damping_reg}) * total_reg;
            ST_TELE_DIV: begin
                i_reg   <= '0;
                j_reg   <= '0;
                acc_reg <= dangling_reg;
                pv_reg  <= 1'b0;
            end
            ST_TELE_WAIT: tele_reg <= div_quo;
            ST_ACC: begin
                pv_reg <= 1'b1;
                if (pv_reg && lnk_rd_row[i_idx]) begin
                    acc_reg <= acc_reg + SW'(share_q_reg);
                end
                j_reg <= j_reg + 1'b1;
            end
            ST_ACC_LAST: begin
                if (lnk_rd_row[i_idx]) begin
                    acc_reg <= acc_reg + SW'(share_q_reg);
                end
            end
            ST_MUL1: begin
                dacc_reg <= damping_reg * acc_reg;
                rold_reg <= rank_rd;
            end
            ST_MUL2: diff_reg <= (v32 > rold_reg) ? (v32 - rold_reg) : (rold_reg - v32);
            ST_MUL3: sq_reg <= diff_reg * diff_reg;
            ST_MUL4: begin
                change_reg <= csum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : csum[63:0];
                i_reg      <= i_reg + 1'b1;
                j_reg      <= '0;
                acc_reg    <= dangling_reg;
                pv_reg     <= 1'b0;
            end
            ST_ITER_END: begin
                if (run_stop) begin
                    m_kind_reg <= conv ? KIND_CONVERGED : KIND_LIMIT;
                    m_page_reg <= '0;
                    m_rank_reg <= '0;
                    m_iter_reg <= count_new;
                end else begin
                    count_reg    <= count_new;
                    j_reg        <= '0;
                    total_reg    <= '0;
                    dangling_reg <= '0;
                    change_reg   <= '0;
                end
            end
            default: ;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_page_index = m_page_reg;
    assign m_rank       = m_rank_reg;
    assign m_iterations = m_iter_reg;

endmodule
